>>> hw/rtl/omad_pkg.sv
// ----------------------------------------------------------------------------
// omad_pkg
// Shared widths, register indexes, result record and segment patterns for the
// autoranging ohmmeter display pipeline.
// ----------------------------------------------------------------------------
package omad_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int IN_FIELD_W      = 10;
  localparam int IN_TDATA_W      = 16;
  localparam int OUT_TDATA_W     = 48;
  localparam int REF_W           = 20;
  localparam int LIM_W           = 17;
  localparam int RES_W           = 27;
  localparam int SEG_W           = 7;
  localparam int LED_W           = 3;
  localparam int DIG_W           = 4;
  localparam int VAL_W           = 17;   // holds every value below 100000

  localparam logic [REF_W-1:0] REF_RESET   = REF_W'(98400);
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(70);
  localparam logic [VAL_W-1:0] LOW_TOP     = VAL_W'(10000);
  localparam logic [VAL_W-1:0] OVL_AT      = VAL_W'(100000);
  localparam logic [RES_W-1:0] RES_MAX     = RES_W'(134217727);
  localparam logic [LED_W-1:0] LED_MAX     = LED_W'(7);

  localparam logic [SEG_W-1:0] SEG_O = 7'h40;
  localparam logic [SEG_W-1:0] SEG_L = 7'h47;

  // Configuration register indexes
  typedef enum logic {
    REG_REF   = 1'b0,
    REG_LIMIT = 1'b1
  } cfg_idx_t;

  // One finished result
  typedef struct packed {
    logic              cont;
    logic [LED_W-1:0]  led;
    logic              ovl;
    logic              point;
    logic [SEG_W-1:0]  lower;
    logic [SEG_W-1:0]  upper;
    logic [RES_W-1:0]  res;
  } res_t;

  // Active-low pattern of one decimal digit, bit0 = a
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd1:    s = 7'h79;
      4'd2:    s = 7'h24;
      4'd3:    s = 7'h30;
      4'd4:    s = 7'h19;
      4'd5:    s = 7'h12;
      4'd6:    s = 7'h02;
      4'd7:    s = 7'h78;
      4'd8:    s = 7'h00;
      4'd9:    s = 7'h10;
      default: s = 7'h40;
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/omad_div.sv
// ----------------------------------------------------------------------------
// omad_div
// Product stage and restoring divider, one quotient bit per register stage:
// R = floor(sample * ref / (2^SAMPLE_BITS - sample)).
// ----------------------------------------------------------------------------
module omad_div #(
  parameter int SAMPLE_BITS = omad_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [SAMPLE_BITS-1:0]                sample,
  input  logic [omad_pkg::REF_W-1:0]            ref_ohms,
  output logic                                  out_valid,
  output logic [SAMPLE_BITS+omad_pkg::REF_W-1:0] quo_out
);

  localparam int NW = SAMPLE_BITS + omad_pkg::REF_W;
  localparam int RW = SAMPLE_BITS + 1;

  logic [NW-1:0] num [0:NW-1];
  logic [RW-1:0] rem [0:NW-1];
  logic [RW-1:0] dvs [0:NW-1];
  logic [NW-1:0] quo [0:NW];
  logic          vld [0:NW];

  // Form the numerator and divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      num[0] <= NW'(sample) * NW'(ref_ohms);
      dvs[0] <= {1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, sample};
      rem[0] <= '0;
      quo[0] <= '0;
    end
  end

  // One trial subtract per stage, numerator bits taken from the top
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [RW-1:0] trial;
    logic          ge;

    assign trial = {rem[k][RW-2:0], num[k][NW-1-k]};
    assign ge    = (trial >= dvs[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        quo[k+1] <= {quo[k][NW-2:0], ge};
      end
    end

    if (k < NW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          num[k+1] <= num[k];
          dvs[k+1] <= dvs[k];
          rem[k+1] <= ge ? (trial - dvs[k]) : trial;
        end
      end
    end
  end

  assign out_valid = vld[NW];
  assign quo_out   = quo[NW];

endmodule

>>> hw/rtl/omad_fmt.sv
// ----------------------------------------------------------------------------
// omad_fmt
// Range decision, two digit extraction stages and segment encoding.
// ----------------------------------------------------------------------------
module omad_fmt #(
  parameter int QW = omad_pkg::SAMPLE_BITS_DEF + omad_pkg::REF_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [QW-1:0]               r,
  input  logic [omad_pkg::LIM_W-1:0]  limit,
  output logic                        out_valid,
  output omad_pkg::res_t              result
);

  localparam int VW = omad_pkg::VAL_W;

  // Stage 1: range flags
  logic                          v1, lo1, mid1, cont1;
  logic [VW-1:0]                 val1;
  logic [omad_pkg::RES_W-1:0]    res1;
  // Stage 2: upper digit
  logic                          v2, lo2, mid2, cont2;
  logic [VW-1:0]                 val2;
  logic [omad_pkg::DIG_W-1:0]    dig_hi2;
  logic [omad_pkg::RES_W-1:0]    res2;
  // Stage 3: output
  logic                          v3;

  logic [VW-1:0]                 unit_hi_sub;
  logic [omad_pkg::DIG_W-1:0]    dig_hi, dig_lo;
  logic [omad_pkg::LED_W-1:0]    led_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Classify and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      lo1   <= (r < QW'(omad_pkg::LOW_TOP));
      mid1  <= (r < QW'(omad_pkg::OVL_AT));
      cont1 <= (r < QW'(limit));
      val1  <= r[VW-1:0];
      res1  <= (r > QW'(omad_pkg::RES_MAX)) ? omad_pkg::RES_MAX : r[omad_pkg::RES_W-1:0];
    end
  end

  // Upper digit: thousands in low range, ten-thousands otherwise
  always_comb begin
    dig_hi      = '0;
    unit_hi_sub = '0;
    for (int k = 1; k < 10; k++) begin
      if (val1 >= (lo1 ? VW'(k * 1000) : VW'(k * 10000))) begin
        dig_hi      = omad_pkg::DIG_W'(k);
        unit_hi_sub = lo1 ? VW'(k * 1000) : VW'(k * 10000);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo2     <= lo1;
      mid2    <= mid1;
      cont2   <= cont1;
      res2    <= res1;
      dig_hi2 <= dig_hi;
      val2    <= val1 - unit_hi_sub;
    end
  end

  // Lower digit from the remainder
  always_comb begin
    dig_lo = '0;
    for (int k = 1; k < 10; k++) begin
      if (val2 >= (lo2 ? VW'(k * 100) : VW'(k * 1000))) begin
        dig_lo = omad_pkg::DIG_W'(k);
      end
    end
  end

  assign led_mid = (dig_hi2 > omad_pkg::DIG_W'(omad_pkg::LED_MAX)) ? omad_pkg::LED_MAX
                                                                     : dig_hi2[omad_pkg::LED_W-1:0];

  // Encode segments and indicators
  always_ff @(posedge clk) begin
    if (en) begin
      result.res  <= res2;
      result.cont <= cont2;
      if (!mid2) begin
        result.upper <= omad_pkg::SEG_O;
        result.lower <= omad_pkg::SEG_L;
        result.point <= 1'b0;
        result.ovl   <= 1'b1;
        result.led   <= omad_pkg::LED_MAX;
      end else begin
        result.upper <= omad_pkg::seg_of(dig_hi2);
        result.lower <= omad_pkg::seg_of(dig_lo);
        result.point <= lo2;
        result.ovl   <= 1'b0;
        result.led   <= lo2 ? '0 : led_mid;
      end
    end
  end

  assign out_valid = v3;

endmodule

>>> hw/rtl/ohmmeter_autorange_display.sv
// From input request to result the pipeline has one product stage, one divider stage
// per quotient bit and three format stages.
// Throughput: one request per cycle; the whole pipeline holds while the result is stalled.
// Reset (synchronous, active high) empties the pipeline and loads the
// reference of 98400 ohms and the continuity limit of 70 ohms.
// ----------------------------------------------------------------------------
// ohmmeter_autorange_display
// Converter sample to resistance, two-digit autoranged display and flags.
// ----------------------------------------------------------------------------
module ohmmeter_autorange_display #(
  parameter int SAMPLE_BITS = omad_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // slave stream: tdata = adc_sample[9:0], zero pad
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [omad_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // master stream: tdata = resistance[26:0], upper_segments[33:27],
  // lower_segments[40:34], point_lit[41], overload[42], range_led[45:43],
  // continuity[46], zero pad
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [omad_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // configuration write port
  input  logic                                cfg_we,
  input  logic                                cfg_addr,
  input  logic [omad_pkg::REF_W-1:0]          cfg_wdata
);

  localparam int QW = SAMPLE_BITS + omad_pkg::REF_W;

  logic [omad_pkg::REF_W-1:0] ref_ohms;
  logic [omad_pkg::LIM_W-1:0] limit;
  logic                       en;
  logic                       div_valid;
  logic [QW-1:0]              quo;
  omad_pkg::res_t             result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_ohms <= omad_pkg::REF_RESET;
      limit    <= omad_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (omad_pkg::cfg_idx_t'(cfg_addr))
        omad_pkg::REG_REF:   ref_ohms <= cfg_wdata;
        omad_pkg::REG_LIMIT: limit    <= cfg_wdata[omad_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless the output is held
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  omad_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .sample    (SAMPLE_BITS'(s_axis_tdata[omad_pkg::IN_FIELD_W-1:0])),
    .ref_ohms  (ref_ohms),
    .out_valid (div_valid),
    .quo_out   (quo)
  );

  omad_fmt #(.QW(QW)) u_fmt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .r         (quo),
    .limit     (limit),
    .out_valid (m_axis_tvalid),
    .result    (result)
  );

  assign m_axis_tdata = {1'b0, result};

  // Overload forces the OL display and top LED code
  a_ovl_display: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && result.ovl) |->
      (result.led == omad_pkg::LED_MAX && !result.point && result.lower == omad_pkg::SEG_L))
    else $error("overload display mismatch");

  // Overload agrees with the reported resistance
  a_ovl_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (result.ovl == (result.res >= omad_pkg::RES_W'(omad_pkg::OVL_AT))))
    else $error("overload flag disagrees with resistance");

  // Point only in the low range
  a_point: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && result.point) |->
      (result.res < omad_pkg::RES_W'(omad_pkg::LOW_TOP) && result.led == '0))
    else $error("point lit outside low range");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

>>> tb/tb_ohmmeter_autorange_display.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ohmmeter_autorange_display
// Drives samples through the ohmmeter display pipeline under random stalls on
// both sides and checks each result with a typed reading or a local predictor
// of the divider formula, range selection, segment patterns and flags.
// ----------------------------------------------------------------------------
module tb_ohmmeter_autorange_display;

  localparam int LATENCY   = omad_pkg::SAMPLE_BITS_DEF + 24;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1150;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [omad_pkg::IN_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [omad_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_we;
  logic cfg_addr;
  logic [omad_pkg::REF_W-1:0] cfg_wdata;

  // Predictor copy of the registers
  logic [omad_pkg::REF_W-1:0] ohms_ref;
  logic [omad_pkg::LIM_W-1:0] cont_lim;

  omad_pkg::res_t reading_q[$];
  int   errors;
  int   wdog;
  int   send_idle_pct;
  int   recv_idle_pct;

  // Directed stimulus: sample, and an optional typed-in reading
  typedef struct {
    logic [9:0]     sample;
    bit             typed;
    omad_pkg::res_t reading;
  } row_t;

  ohmmeter_autorange_display DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [omad_pkg::SEG_W-1:0] digit_pattern(input logic [63:0] d);
    logic [omad_pkg::SEG_W-1:0] p;
    case (d)
      1: p = 7'h79;
      2: p = 7'h24;
      3: p = 7'h30;
      4: p = 7'h19;
      5: p = 7'h12;
      6: p = 7'h02;
      7: p = 7'h78;
      8: p = 7'h00;
      9: p = 7'h10;
      default: p = 7'h40;
    endcase
    return p;
  endfunction

  // Work out the displayed reading for one sample
  function automatic omad_pkg::res_t reading_of(input logic [9:0] sample);
    omad_pkg::res_t o;
    logic [63:0] r;
    logic [63:0] s;
    s = 64'(sample);
    r = (s * 64'(ohms_ref)) / (64'd1024 - s);
    o.res = (r > 64'(omad_pkg::RES_MAX)) ? omad_pkg::RES_MAX : r[omad_pkg::RES_W-1:0];
    if (r < 64'd10000) begin
      o.upper = digit_pattern(r / 1000);
      o.lower = digit_pattern((r / 100) % 10);
      o.point = 1'b1;
      o.ovl   = 1'b0;
      o.led   = 3'd0;
    end else if (r < 64'd100000) begin
      o.upper = digit_pattern(r / 10000);
      o.lower = digit_pattern((r / 1000) % 10);
      o.point = 1'b0;
      o.ovl   = 1'b0;
      o.led   = (r / 10000 > 7) ? 3'd7 : 3'((r / 10000));
    end else begin
      o.upper = omad_pkg::SEG_O;
      o.lower = omad_pkg::SEG_L;
      o.point = 1'b0;
      o.ovl   = 1'b1;
      o.led   = omad_pkg::LED_MAX;
    end
    o.cont = (r < 64'(cont_lim));
    return o;
  endfunction

  // Write one register while the pipeline is empty
  task automatic write_reg(input omad_pkg::cfg_idx_t idx,
                           input logic [omad_pkg::REF_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == omad_pkg::REG_REF) ohms_ref = val;
    else cont_lim = val[omad_pkg::LIM_W-1:0];
  endtask

  // Drop the request and hold until every pending reading has drained
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (reading_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Send one request, idling the sender at random
  task automatic send_sample(input logic [9:0] sample, input bit typed,
                             input omad_pkg::res_t given);
    omad_pkg::res_t exp_r;
    exp_r = typed ? given : reading_of(sample);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= omad_pkg::IN_TDATA_W'(sample);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    reading_q.push_back(exp_r);
  endtask

  // Receiver: random stalls and result checks
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        omad_pkg::res_t got;
        omad_pkg::res_t want;
        got = omad_pkg::res_t'(m_axis_tdata[$bits(omad_pkg::res_t)-1:0]);
        if (reading_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = reading_q.pop_front();
          if (got !== want ||
              m_axis_tdata[omad_pkg::OUT_TDATA_W-1:$bits(omad_pkg::res_t)] !== '0) begin
            $display("%0t: expected res=%0d up=%h lo=%h pt=%b ovl=%b led=%0d cont=%b",
                     $time, want.res, want.upper, want.lower, want.point, want.ovl,
                     want.led, want.cont);
            $display("%0t: actual   res=%0d up=%h lo=%h pt=%b ovl=%b led=%0d cont=%b",
                     $time, got.res, got.upper, got.lower, got.point, got.ovl,
                     got.led, got.cont);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no accepted request or result
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      wdog <= 0;
    else if (wdog >= WDOG_MAX) begin
      $display("Mismatches found");
      $finish;
    end else
      wdog <= wdog + 1;
  end

  initial begin
    row_t rows[$];
    omad_pkg::res_t typed_r;
    int phase;
    int k;
    logic [omad_pkg::REF_W-1:0] refs[6];
    logic [omad_pkg::LIM_W-1:0] lims[6];
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = omad_pkg::REG_REF;
    cfg_wdata = '0;
    errors = 0;
    wdog = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    ohms_ref = omad_pkg::REF_RESET;
    cont_lim = omad_pkg::LIMIT_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table; sample 0 is zero ohms, full scale sample is overload
    typed_r = '{cont: 1'b1, led: 3'd0, ovl: 1'b0, point: 1'b1,
                lower: 7'h40, upper: 7'h40, res: '0};
    rows.push_back('{10'd0, 1'b1, typed_r});
    typed_r = '{cont: 1'b0, led: 3'd7, ovl: 1'b1, point: 1'b0,
                lower: omad_pkg::SEG_L, upper: omad_pkg::SEG_O,
                res: omad_pkg::RES_W'(100663200)};
    rows.push_back('{10'd1023, 1'b1, typed_r});
    for (k = 1; k < 1023; k += 73) rows.push_back('{10'(k), 1'b0, '0});
    rows.push_back('{10'd512, 1'b0, '0});
    rows.push_back('{10'd1, 1'b0, '0});
    rows.push_back('{10'h2AA, 1'b0, '0});
    rows.push_back('{10'h155, 1'b0, '0});
    foreach (rows[i]) send_sample(rows[i].sample, rows[i].typed, rows[i].reading);
    drain();

    // Reference of zero, exact overload boundary (512 * 100000 / 512)
    write_reg(omad_pkg::REG_REF, '0);
    write_reg(omad_pkg::REG_LIMIT, omad_pkg::REF_W'(100000));
    send_sample(10'd700, 1'b0, '0);
    drain();
    write_reg(omad_pkg::REG_REF, omad_pkg::REF_W'(100000));
    write_reg(omad_pkg::REG_LIMIT, '0);
    typed_r = '{cont: 1'b0, led: 3'd7, ovl: 1'b1, point: 1'b0,
                lower: omad_pkg::SEG_L, upper: omad_pkg::SEG_O,
                res: omad_pkg::RES_W'(100000)};
    send_sample(10'd512, 1'b1, typed_r);
    send_sample(10'd511, 1'b0, '0);
    send_sample(10'd700, 1'b0, '0);
    drain();

    refs = '{omad_pkg::REF_W'(1), omad_pkg::REF_W'(1000000), omad_pkg::REF_W'(98400),
             omad_pkg::REF_W'(10000), omad_pkg::REF_W'(1048575), omad_pkg::REF_W'(4700)};
    lims = '{omad_pkg::LIM_W'(0), omad_pkg::LIM_W'(100000), omad_pkg::LIM_W'(70),
             omad_pkg::LIM_W'(131071), omad_pkg::LIM_W'(5000), omad_pkg::LIM_W'(1)};
    for (phase = 0; phase < 6; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 9; recv_idle_pct = 70;
      end else if (phase < 4) begin
        send_idle_pct = 70; recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      write_reg(omad_pkg::REG_REF, refs[phase]);
      write_reg(omad_pkg::REG_LIMIT, omad_pkg::REF_W'(lims[phase]));
      for (k = 0; k < N_RANDOM / 6; k++)
        send_sample(10'($urandom_range(1023)), 1'b0, '0);
      drain();
    end

    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/omad_pkg.sv
hw/rtl/omad_div.sv
hw/rtl/omad_fmt.sv
hw/rtl/ohmmeter_autorange_display.sv
tb/tb_ohmmeter_autorange_display.sv
